>>> src/mwe_pkg.sv
// shared types and constants for the microwire eeprom master
// no dependencies; imported by mwe_step, microwire_eeprom_master_core, mwe_checker and tb
`timescale 1ns / 1ps
`default_nettype none

package mwe_pkg;

    // sequencer phases, one-hot
    typedef enum logic [7:0] {
        PH_IDLE       = 8'b0000_0001,
        PH_SEND_READ  = 8'b0000_0010,
        PH_SEND_WRITE = 8'b0000_0100,
        PH_SEND_EWEN  = 8'b0000_1000,
        PH_SEND_EWDS  = 8'b0001_0000,
        PH_RECV       = 8'b0010_0000,
        PH_GAP        = 8'b0100_0000,
        PH_POLL       = 8'b1000_0000
    } phase_t;

    // request modes
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_EWEN  = 3'd3;
    localparam logic [2:0] MODE_EWDS  = 3'd4;

    // opcodes
    localparam logic [1:0] OP_READ  = 2'b10;
    localparam logic [1:0] OP_WRITE = 2'b01;
    localparam logic [1:0] OP_CTRL  = 2'b00;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_ENABLED = 2'd1;
    localparam logic [1:0] ST_TIMEOUT     = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LONG_MODE     = 2'd0;
    localparam logic [1:0] CFG_POLL_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_POLL_INTERVAL = 2'd2;

    // reset values of the configuration registers
    localparam logic        LONG_MODE_RST     = 1'b1;
    localparam logic [7:0]  POLL_LIMIT_RST    = 8'd20;
    localparam logic [15:0] POLL_INTERVAL_RST = 16'd1000;

    localparam int SHIFT_W = 26;

    typedef struct packed {
        phase_t               phase;
        logic [SHIFT_W-1:0]   shift_word;
        logic [4:0]           bits_left;
        logic [15:0]          read_accum;
        logic                 write_enabled;
        logic [7:0]           poll_count;
        logic [15:0]          interval_count;
    } seq_state_t;

    typedef struct packed {
        logic        long_mode;
        logic [7:0]  poll_limit;
        logic [15:0] poll_interval;
    } seq_cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  address;
        logic [15:0] write_data;
        logic        do_level;
    } slot_in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  status;
        logic        done_res;
        logic        busy_res;
        logic        serial_out;
        logic        clock_pulse;
        logic        chip_select;
    } slot_out_t;

endpackage

`default_nettype wire

>>> src/mwe_step.sv
// next-state and slot output logic of the microwire sequencer
// depends on mwe_pkg
`timescale 1ns / 1ps
`default_nettype none

module mwe_step
    import mwe_pkg::*;
(
    input  wire seq_state_t cur,
    input  wire seq_cfg_t   cfg,
    input  wire slot_in_t   slot,
    output seq_state_t      nxt,
    output slot_out_t       res
);

    always_comb begin
        logic [SHIFT_W-1:0] frame_rd;
        logic [SHIFT_W-1:0] frame_wr;
        logic [SHIFT_W-1:0] frame_en;
        logic [SHIFT_W-1:0] frame_ds;
        logic [4:0]         frame_len;
        logic [4:0]         bl_dec;

        nxt = cur;
        res = '0;

        // frames: start bit, opcode, address
        if (cfg.long_mode) begin
            frame_rd  = {17'd0, 1'b1, OP_READ,  slot.address[5:0]};
            frame_wr  = {1'b0, 1'b1, OP_WRITE, slot.address[5:0], slot.write_data};
            frame_en  = {17'd0, 1'b1, OP_CTRL, 6'h30};
            frame_ds  = {17'd0, 1'b1, OP_CTRL, 6'h00};
            frame_len = 5'd9;
        end else begin
            frame_rd  = {16'd0, 1'b1, OP_READ,  slot.address};
            frame_wr  = {8'd0, 1'b1, OP_WRITE, slot.address, slot.write_data[7:0]};
            frame_en  = {16'd0, 1'b1, OP_CTRL, 7'h60};
            frame_ds  = {16'd0, 1'b1, OP_CTRL, 7'h00};
            frame_len = 5'd10;
        end

        // command start
        if (cur.phase == PH_IDLE) begin
            unique case (slot.mode)
                MODE_READ: begin
                    nxt.shift_word = frame_rd |
                        (cfg.long_mode ? SHIFT_W'(16) << 20 : SHIFT_W'(8) << 20);
                    nxt.bits_left  = frame_len;
                    nxt.read_accum = '0;
                    nxt.phase      = PH_SEND_READ;
                end
                MODE_WRITE: begin
                    if (!cur.write_enabled) begin
                        res.done_res = 1'b1;
                        res.status   = ST_NOT_ENABLED;
                    end else begin
                        nxt.shift_word = frame_wr;
                        nxt.bits_left  = cfg.long_mode ? 5'd25 : 5'd18;
                        nxt.phase      = PH_SEND_WRITE;
                    end
                end
                MODE_EWEN: begin
                    nxt.shift_word = frame_en;
                    nxt.bits_left  = frame_len;
                    nxt.phase      = PH_SEND_EWEN;
                end
                MODE_EWDS: begin
                    nxt.shift_word = frame_ds;
                    nxt.bits_left  = frame_len;
                    nxt.phase      = PH_SEND_EWDS;
                end
                default: ;
            endcase
        end

        bl_dec = nxt.bits_left - 5'd1;

        unique case (nxt.phase)
            PH_SEND_READ, PH_SEND_WRITE, PH_SEND_EWEN, PH_SEND_EWDS: begin
                res.chip_select = 1'b1;
                res.clock_pulse = 1'b1;
                if (nxt.bits_left != 5'd0 && nxt.bits_left <= 5'd26) begin
                    res.serial_out = nxt.shift_word[bl_dec];
                    nxt.bits_left  = bl_dec;
                end else begin
                    nxt.bits_left = '0;
                end
                if (nxt.bits_left == 5'd0) begin
                    priority case (nxt.phase)
                        PH_SEND_READ: begin
                            nxt.bits_left = nxt.shift_word[24:20];
                            nxt.phase     = PH_RECV;
                        end
                        PH_SEND_WRITE: begin
                            nxt.poll_count     = '0;
                            nxt.interval_count = '0;
                            nxt.phase          = PH_GAP;
                        end
                        default: begin
                            nxt.write_enabled = (nxt.phase == PH_SEND_EWEN);
                            res.done_res      = 1'b1;
                            nxt.phase         = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_RECV: begin
                res.chip_select = 1'b1;
                res.clock_pulse = 1'b1;
                nxt.read_accum  = {nxt.read_accum[14:0], slot.do_level};
                if (nxt.bits_left != 5'd0) begin
                    nxt.bits_left = bl_dec;
                end
                if (nxt.bits_left == 5'd0) begin
                    res.done_res  = 1'b1;
                    res.read_data = nxt.read_accum;
                    nxt.phase     = PH_IDLE;
                end
            end
            PH_GAP: begin
                nxt.phase = PH_POLL;
            end
            PH_POLL: begin
                res.chip_select = 1'b1;
                if (nxt.interval_count != 16'd0) begin
                    nxt.interval_count = nxt.interval_count - 16'd1;
                end else if (slot.do_level) begin
                    res.done_res = 1'b1;
                    nxt.phase    = PH_IDLE;
                end else if (nxt.poll_count >= cfg.poll_limit) begin
                    res.done_res = 1'b1;
                    res.status   = ST_TIMEOUT;
                    nxt.phase    = PH_IDLE;
                end else begin
                    nxt.poll_count     = nxt.poll_count + 8'd1;
                    nxt.interval_count = (cfg.poll_interval != 16'd0) ?
                                         cfg.poll_interval - 16'd1 : 16'd0;
                end
            end
            default: ;
        endcase

        res.busy_res = (nxt.phase != PH_IDLE);
    end

endmodule

`default_nettype wire

>>> src/microwire_eeprom_master_core.sv
// microwire master for a 93c46 serial eeprom, one bit slot per transfer
// depends on mwe_pkg and mwe_step
//
// usage:
//   s_ channel: one transfer per serial bit slot. a transfer may start a
//   command (read, write, write enable, write disable) while the block is
//   idle; every transfer also carries the sampled DO level of the eeprom.
//   m_ channel: exactly one result transfer per input transfer, giving the
//   chip select, clock pulse and DI levels for the slot plus busy, done,
//   status and read data.
//   cfg channel: register writes (index 0 long_mode, 1 poll_limit,
//   2 poll_interval); always ready; the user must write it only while idle, the block does not enforce this.
// output: the result of a slot is registered and on m_ in the cycle after its transfer.
// throughput: one slot per cycle unless a pending result stalls; the sequencer state and the result
//   register update together in the cycle of the input transfer.
// reset: aresetn low puts the sequencer in idle with writes disabled and
//   loads the register defaults (16-bit mode, 20 polls, 1000 slot interval).
// stall: while m_tready is low with a result pending, s_tready drops; the
//   pending result and the sequencer state hold until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module microwire_eeprom_master_core
    import mwe_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    // input slot
    input  wire        s_tvalid,
    output logic       s_tready,
    // mode[2:0], address[9:3], write_data[25:10], do_level[26], zero pad
    input  wire [31:0] s_tdata,
    // slot result
    output logic       m_tvalid,
    input  wire        m_tready,
    // chip_select[0], clock_pulse[1], serial_out[2], busy_res[3],
    // done_res[4], status[6:5], read_data[22:7], zero pad
    output logic [23:0] m_tdata,
    // configuration writes
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [1:0]  cfg_index,
    input  wire [15:0] cfg_data
);

    seq_state_t st_reg;
    seq_state_t st_next;
    seq_cfg_t   cfg_reg;
    slot_in_t   slot;
    slot_out_t  res_next;
    slot_out_t  res_reg;
    logic       m_tvalid_reg;
    logic       s_xfer;
    logic       m_xfer;

    // output register frees up when empty or being taken this cycle
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_xfer    = m_tvalid_reg && m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, res_reg};
    assign cfg_ready = 1'b1;

    // unpack the input transfer
    assign slot.mode       = s_tdata[2:0];
    assign slot.address    = s_tdata[9:3];
    assign slot.write_data = s_tdata[25:10];
    assign slot.do_level   = s_tdata[26];

    mwe_step u_step (
        .cur  (st_reg),
        .cfg  (cfg_reg),
        .slot (slot),
        .nxt  (st_next),
        .res  (res_next)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_mode     <= LONG_MODE_RST;
            cfg_reg.poll_limit    <= POLL_LIMIT_RST;
            cfg_reg.poll_interval <= POLL_INTERVAL_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LONG_MODE:     cfg_reg.long_mode     <= cfg_data[0];
                CFG_POLL_LIMIT:    cfg_reg.poll_limit    <= cfg_data[7:0];
                CFG_POLL_INTERVAL: cfg_reg.poll_interval <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state advances once per accepted slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase          <= PH_IDLE;
            st_reg.shift_word     <= '0;
            st_reg.bits_left      <= '0;
            st_reg.read_accum     <= '0;
            st_reg.write_enabled  <= 1'b0;
            st_reg.poll_count     <= '0;
            st_reg.interval_count <= '0;
        end else if (s_xfer) begin
            st_reg <= st_next;
        end
    end

    // result register, payload without reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_xfer) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= res_next;
        end
    end

    // busy flag of a fresh result matches the sequencer phase it left behind
    a_busy_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (res_reg.busy_res == (st_reg.phase != PH_IDLE)))
        else $error("busy flag disagrees with sequencer phase");

    // a finishing slot never leaves the block busy
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && res_reg.done_res |-> !res_reg.busy_res)
        else $error("done with busy set");

    // status and read data only appear on a done slot
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !res_reg.done_res |->
            (res_reg.status == ST_OK) && (res_reg.read_data == 16'd0))
        else $error("status or read data outside a done slot");

    // write enable flag only moves with an accepted slot
    a_we_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_xfer |=> $stable(st_reg.write_enabled))
        else $error("write enable changed without a slot transfer");

    // a stalled result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(res_reg))
        else $error("pending result changed while stalled");

endmodule

`default_nettype wire

>>> bench/mwe_checker.sv
// slot-accurate predictor and result checker for the microwire eeprom master
// depends on mwe_pkg; instantiated beside the block by tb
`timescale 1ns / 1ps

module mwe_checker
    import mwe_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire [31:0] s_tdata,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [23:0] m_tdata,
    input  wire        cfg_valid,
    input  wire        cfg_ready,
    input  wire [1:0]  cfg_index,
    input  wire [15:0] cfg_data,
    output logic       seq_idle,
    output int         pending,
    output int         fail_count,
    output int         done_count,
    output int         timeout_count,
    output int         refused_count
);

    // register copies
    logic        cfg_long;
    logic [7:0]  cfg_limit;
    logic [15:0] cfg_interval;

    // sequencer copy
    phase_t      seq_phase;
    logic [25:0] frame_word;
    logic [4:0]  bits_to_go;
    logic [15:0] rx_word;
    logic        wr_enabled;
    logic [7:0]  failed_polls;
    logic [15:0] poll_wait;

    slot_out_t   expected_slots[$];
    int          result_index;

    // start bit, opcode, address, MSB first
    function automatic logic [25:0] cmd_frame(input logic [1:0] op, input logic [6:0] arg,
                                              input int unsigned nab);
        return (26'd1 << (nab + 2)) | (26'(op) << nab) | 26'(arg);
    endfunction

    function automatic slot_out_t advance_sequencer(input slot_in_t si);
        slot_out_t   r;
        int unsigned nab;
        logic [6:0]  amask;
        r = '0;
        // command start, only from idle
        if (seq_phase == PH_IDLE && si.mode >= MODE_READ && si.mode <= MODE_EWDS) begin
            nab   = cfg_long ? 6 : 7;
            amask = cfg_long ? 7'h3F : 7'h7F;
            case (si.mode)
                MODE_READ: begin
                    frame_word = cmd_frame(OP_READ, si.address & amask, nab);
                    frame_word[24:20] = cfg_long ? 5'd16 : 5'd8;
                    bits_to_go = 5'(nab + 3);
                    rx_word    = '0;
                    seq_phase  = PH_SEND_READ;
                end
                MODE_WRITE: begin
                    if (!wr_enabled) begin
                        r.done_res = 1'b1;
                        r.status   = ST_NOT_ENABLED;
                    end else begin
                        if (cfg_long) begin
                            frame_word = (cmd_frame(OP_WRITE, si.address & amask, nab) << 16)
                                         | 26'(si.write_data);
                            bits_to_go = 5'(nab + 19);
                        end else begin
                            frame_word = (cmd_frame(OP_WRITE, si.address & amask, nab) << 8)
                                         | 26'(si.write_data[7:0]);
                            bits_to_go = 5'(nab + 11);
                        end
                        seq_phase = PH_SEND_WRITE;
                    end
                end
                MODE_EWEN: begin
                    // control opcode with 11 in the top address bits
                    frame_word = cmd_frame(OP_CTRL, cfg_long ? 7'h30 : 7'h60, nab);
                    bits_to_go = 5'(nab + 3);
                    seq_phase  = PH_SEND_EWEN;
                end
                default: begin
                    frame_word = cmd_frame(OP_CTRL, 7'h00, nab);
                    bits_to_go = 5'(nab + 3);
                    seq_phase  = PH_SEND_EWDS;
                end
            endcase
        end

        case (seq_phase)
            PH_SEND_READ, PH_SEND_WRITE, PH_SEND_EWEN, PH_SEND_EWDS: begin
                r.chip_select = 1'b1;
                r.clock_pulse = 1'b1;
                if (bits_to_go != 0) begin
                    r.serial_out = frame_word[bits_to_go - 5'd1];
                    bits_to_go   = bits_to_go - 5'd1;
                end
                if (bits_to_go == 0) begin
                    if (seq_phase == PH_SEND_READ) begin
                        bits_to_go = frame_word[24:20];
                        seq_phase  = PH_RECV;
                    end else if (seq_phase == PH_SEND_WRITE) begin
                        failed_polls = '0;
                        poll_wait    = '0;
                        seq_phase    = PH_GAP;
                    end else begin
                        wr_enabled = (seq_phase == PH_SEND_EWEN);
                        r.done_res = 1'b1;
                        seq_phase  = PH_IDLE;
                    end
                end
            end
            PH_RECV: begin
                r.chip_select = 1'b1;
                r.clock_pulse = 1'b1;
                rx_word = {rx_word[14:0], si.do_level};
                if (bits_to_go != 0)
                    bits_to_go = bits_to_go - 5'd1;
                if (bits_to_go == 0) begin
                    r.done_res  = 1'b1;
                    r.read_data = rx_word;
                    seq_phase   = PH_IDLE;
                end
            end
            PH_GAP: seq_phase = PH_POLL;
            PH_POLL: begin
                r.chip_select = 1'b1;
                if (poll_wait != 0) begin
                    poll_wait = poll_wait - 16'd1;
                end else if (si.do_level) begin
                    r.done_res = 1'b1;
                    seq_phase  = PH_IDLE;
                end else if (failed_polls >= cfg_limit) begin
                    r.done_res = 1'b1;
                    r.status   = ST_TIMEOUT;
                    seq_phase  = PH_IDLE;
                end else begin
                    failed_polls = failed_polls + 8'd1;
                    poll_wait    = (cfg_interval != 0) ? cfg_interval - 16'd1 : 16'd0;
                end
            end
            default: ;
        endcase
        r.busy_res = (seq_phase != PH_IDLE);
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        slot_in_t  si;
        slot_out_t want;
        slot_out_t got;
        if (!aresetn) begin
            cfg_long      = LONG_MODE_RST;
            cfg_limit     = POLL_LIMIT_RST;
            cfg_interval  = POLL_INTERVAL_RST;
            seq_phase     = PH_IDLE;
            frame_word    = '0;
            bits_to_go    = '0;
            rx_word       = '0;
            wr_enabled    = 1'b0;
            failed_polls  = '0;
            poll_wait     = '0;
            expected_slots.delete();
            result_index  = 0;
            fail_count    = 0;
            done_count    = 0;
            timeout_count = 0;
            refused_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LONG_MODE:     cfg_long     = cfg_data[0];
                    CFG_POLL_LIMIT:    cfg_limit    = cfg_data[7:0];
                    CFG_POLL_INTERVAL: cfg_interval = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                si.mode       = s_tdata[2:0];
                si.address    = s_tdata[9:3];
                si.write_data = s_tdata[25:10];
                si.do_level   = s_tdata[26];
                want = advance_sequencer(si);
                expected_slots.push_back(want);
                if (want.done_res) done_count++;
                if (want.done_res && want.status == ST_TIMEOUT) timeout_count++;
                if (want.done_res && want.status == ST_NOT_ENABLED) refused_count++;
            end
            if (m_tvalid && m_tready) begin
                got = slot_out_t'(m_tdata[22:0]);
                if (expected_slots.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result %0d arrived with nothing expected (data %h)",
                                 $realtime, result_index, m_tdata);
                end else begin
                    want = expected_slots.pop_front();
                    if (got.chip_select !== want.chip_select ||
                        got.clock_pulse !== want.clock_pulse ||
                        got.serial_out  !== want.serial_out  ||
                        got.busy_res    !== want.busy_res    ||
                        got.done_res    !== want.done_res    ||
                        got.status      !== want.status      ||
                        got.read_data   !== want.read_data) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: result %0d mismatch: expected cs %b sk %b di %b ",
                                      "busy %b done %b status %0d rd %h, got cs %b sk %b ",
                                      "di %b busy %b done %b status %0d rd %h"},
                                     $realtime, result_index,
                                     want.chip_select, want.clock_pulse, want.serial_out,
                                     want.busy_res, want.done_res, want.status, want.read_data,
                                     got.chip_select, got.clock_pulse, got.serial_out,
                                     got.busy_res, got.done_res, got.status, got.read_data);
                    end
                end
                result_index++;
            end
        end
        pending  = expected_slots.size();
        seq_idle = (seq_phase == PH_IDLE);
    end

endmodule

>>> bench/tb.sv
// top of the microwire eeprom master bench: clock, reset, stimulus and verdict
// depends on mwe_pkg, mwe_checker and microwire_eeprom_master_core
`timescale 1ns / 1ps

module tb;
    import mwe_pkg::*;

    // plain tick, no command
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_MAX     = 3'd7;
    // cycles without any transfer before the run is declared hung
    localparam int         STALL_LIMIT  = 5000;
    // random slots per idling phase
    localparam int         RANDOM_SLOTS = 50;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    logic [31:0] s_tdata   = '0;
    wire         m_tvalid;
    logic        m_tready  = 1'b1;
    wire  [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [1:0]  cfg_index = CFG_LONG_MODE;
    logic [15:0] cfg_data  = '0;

    wire seq_idle;
    int  pending;
    int  fail_count;
    int  done_count;
    int  timeout_count;
    int  refused_count;

    // idling controls, in percent of cycles
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned slots_sent     = 0;
    int unsigned quiet_cycles   = 0;

    // per random phase: sender idle, receiver stall, register settings
    int unsigned phase_src_pct[4]  = '{0, 62, 0, 30};
    int unsigned phase_sink_pct[4] = '{0, 0, 62, 30};
    logic        phase_long[4]     = '{1'b1, 1'b0, 1'b1, 1'b0};
    logic [7:0]  phase_limit[4]    = '{8'd3, 8'd1, 8'd0, 8'd6};
    logic [15:0] phase_interval[4] = '{16'd2, 16'd5, 16'd1, 16'd3};

    microwire_eeprom_master_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mwe_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .seq_idle      (seq_idle),
        .pending       (pending),
        .fail_count    (fail_count),
        .done_count    (done_count),
        .timeout_count (timeout_count),
        .refused_count (refused_count)
    );

    always #5 aclk = ~aclk;

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // hang detector: any transfer on any channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results still due",
                     STALL_LIMIT, pending);
            $display("microwire_eeprom_master_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // do level for the n-th slot of a command: low for the first low_slots,
    // then high with the given chance
    function automatic logic do_bit(input int unsigned n, input int unsigned low_slots,
                                    input int unsigned high_pct);
        return (n >= low_slots) && ($urandom_range(0, 99) < high_pct);
    endfunction

    // one input transfer; starts and ends at a falling edge, leaves tvalid high
    task automatic send_slot(input logic [2:0] mode, input logic [6:0] addr,
                             input logic [15:0] wdata, input logic dol);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, dol, wdata, addr, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        slots_sent++;
    endtask

    // issue a command slot, then keep ticking until the sequencer is idle;
    // slots sent while busy carry random requests that must be ignored
    task automatic run_cmd(input logic [2:0] mode, input logic [6:0] addr,
                           input logic [15:0] wdata, input int unsigned low_slots,
                           input int unsigned high_pct);
        int unsigned n;
        n = 0;
        send_slot(mode, addr, wdata, do_bit(n, low_slots, high_pct));
        while (!seq_idle) begin
            n++;
            send_slot(3'($urandom_range(0, MODE_MAX)), 7'($urandom_range(0, 127)),
                      16'($urandom_range(0, 65535)), do_bit(n, low_slots, high_pct));
        end
    endtask

    // stop sending and wait until every expected result has been taken
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // every result is registered in the cycle after its slot, so an empty queue means no result is pending
    task automatic set_config(input logic lmode, input logic [7:0] limit,
                              input logic [15:0] interval);
        write_reg(CFG_LONG_MODE, {15'd0, lmode});
        write_reg(CFG_POLL_LIMIT, {8'd0, limit});
        write_reg(CFG_POLL_INTERVAL, interval);
    endtask

    initial begin : stimulus
        int unsigned r;
        int unsigned start;
        int          p;
        logic [2:0]  mode;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, register defaults first (16-bit, 20 polls, 1000 slots)
        run_cmd(MODE_WRITE, 7'h7F, 16'hFFFF, 0, 100);   // refused, writes still disabled
        run_cmd(3'd5, 7'h00, 16'h0000, 0, 0);           // unknown modes act as ticks
        run_cmd(3'd6, 7'h7F, 16'hFFFF, 0, 100);
        run_cmd(MODE_MAX, 7'h55, 16'h5555, 0, 50);
        run_cmd(MODE_TICK, 7'h2A, 16'hAAAA, 0, 50);
        run_cmd(MODE_READ, 7'h00, 16'h0000, 0, 100);    // all-ones word
        run_cmd(MODE_READ, 7'h7F, 16'hFFFF, 1000, 0);   // all-zeros, address above 6 bits
        run_cmd(MODE_EWEN, 7'h55, 16'h0000, 0, 50);
        // first poll ready right after the cs-low slot
        run_cmd(MODE_WRITE, 7'h00, 16'h0000, 26, 100);
        run_cmd(MODE_EWDS, 7'h7F, 16'hFFFF, 0, 50);
        run_cmd(MODE_WRITE, 7'h11, 16'h1234, 0, 50);    // refused again

        // 8-bit organization, zero poll limit, zero interval
        drain_block();
        set_config(1'b0, 8'd0, 16'd0);
        run_cmd(MODE_READ, 7'h7F, 16'h0000, 0, 50);
        run_cmd(MODE_READ, 7'h00, 16'hFFFF, 0, 100);
        run_cmd(MODE_EWEN, 7'h00, 16'h0000, 0, 50);
        run_cmd(MODE_WRITE, 7'h7F, 16'hFFFF, 1000, 0);  // first failed poll times out
        drain_block();
        set_config(1'b0, 8'd1, 16'd0);                  // zero interval acts as one
        run_cmd(MODE_WRITE, 7'h40, 16'h00FF, 1000, 0);
        // widest limit: 255 failed polls allowed
        drain_block();
        set_config(1'b1, 8'd255, 16'd1);
        run_cmd(MODE_WRITE, 7'h3F, 16'hFFFF, 1000, 0);
        // widest interval setting, ready on the first poll
        drain_block();
        set_config(1'b1, 8'd255, 16'd65535);
        run_cmd(MODE_WRITE, 7'h15, 16'h8001, 26, 100);
        run_cmd(MODE_EWDS, 7'h00, 16'h0000, 0, 50);

        // random part, one idling style per phase
        for (p = 0; p < 4; p++) begin
            drain_block();
            src_idle_pct   = phase_src_pct[p];
            sink_stall_pct <= phase_sink_pct[p];
            set_config(phase_long[p], phase_limit[p], phase_interval[p]);
            start = slots_sent;
            while (slots_sent - start < RANDOM_SLOTS) begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    mode = MODE_TICK;
                else if (r < 37)
                    mode = MODE_READ;
                else if (r < 65)
                    mode = MODE_WRITE;
                else if (r < 80)
                    mode = MODE_EWEN;
                else if (r < 88)
                    mode = MODE_EWDS;
                else
                    mode = 3'($urandom_range(MODE_EWDS + 1, MODE_MAX));
                run_cmd(mode, 7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
                        0, $urandom_range(15, 85));
                // now and then hold the sender until all results are back
                if ($urandom_range(0, 19) == 0)
                    drain_block();
            end
        end

        drain_block();
        sink_stall_pct <= 0;
        repeat (4) @(posedge aclk);

        $display("covered %0d slots, %0d finished commands (%0d ready timeouts, %0d refused writes)",
                 slots_sent, done_count, timeout_count, refused_count);
        $display("both organizations, poll limits 0 to 255, intervals 0 to 65535, four idling styles");
        if (fail_count == 0 && pending == 0) begin
            $display("microwire_eeprom_master_core verification clean");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count, pending);
            $display("microwire_eeprom_master_core verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/mwe_pkg.sv
src/mwe_step.sv
src/microwire_eeprom_master_core.sv
bench/mwe_checker.sv
bench/tb.sv
